// File: src/uart_receiver_with_fifo_unit_assert.svh
// Assertion macros shared by the receiver RTL; they compile to nothing in synthesis.
`ifndef UART_RECEIVER_WITH_FIFO_UNIT_ASSERT_SVH
`define UART_RECEIVER_WITH_FIFO_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define UFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uart receiver assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define UFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uart receiver assertion failed");
`else
`define UFR_ASSERT_NOW(lbl, ante, cons)
`define UFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/ufr_pkg.sv
// Types and constants of the UART receiver with receive FIFO.
`timescale 1ns / 1ps

package ufr_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_DELAY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIT_DELAY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STOP_DELAY   = 3'd4;

  localparam int CfgDataW = 16;
  localparam int FillW    = 6;

  // One input item: a line sample plus FIFO strobes.
  typedef struct packed {
    logic line_level;
    logic pop_request;
    logic flush_request;
  } ufr_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0]       head_byte;
    logic             head_valid;
    logic [FillW-1:0] fill_count;
    logic             overflow;
    logic             byte_done;
  } ufr_out_t;

endpackage

// File: src/uart_receiver_with_fifo_unit.sv
// UART 8N1 receiver with a ring FIFO, one line sample tick per item.
//
// Usage: every input item carries one sample of the receive line plus pop and
// flush strobes. Every accepted item yields exactly one result item, showing
// the FIFO head byte and fill count as they were before this item's pop, the
// sticky overflow flag and a strobe for a frame completed on this tick.
// The registers (enable, invert, center, bit and stop delay) are written over
// the cfg_ port while no item is in flight. Enabling the receiver empties the
// FIFO and clears overflow; disabling aborts a frame in progress.
// A result appears in the cycle after its item is taken.
// Throughput is one item per cycle unless results stall, set by the single result
// register; the head byte comes from a synchronous read of the FIFO memory into
// that stage. When the receiver of results stalls, the result register holds and
// the input channel is stalled; no item is lost or repeated.
// Reset (synchronous, active low) disables the receiver, clears all registers
// but the head read register, clears the pointers and leaves no result pending.
// The FIFO memory is not cleared; its unwritten entries are never shown.
`timescale 1ns / 1ps
`include "uart_receiver_with_fifo_unit_assert.svh"

module uart_receiver_with_fifo_unit #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ufr_pkg::ufr_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ufr_pkg::ufr_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [ufr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ufr_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ufr_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [PtrW:0]   DepthExt = (PtrW + 1)'(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CENTER,
    PH_DATA,
    PH_STOP
  } rx_phase_t;

  // Configuration registers.
  logic        enable_r, enable_nxt;
  logic        invert_r, invert_nxt;
  logic [15:0] center_delay_r, center_delay_nxt;
  logic [15:0] bit_delay_r, bit_delay_nxt;
  logic [15:0] stop_delay_r, stop_delay_nxt;

  // Receiver and FIFO control state.
  rx_phase_t   phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic        overflow_r, overflow_nxt;
  logic [PtrW-1:0] head_ptr_r, head_ptr_nxt;
  logic [PtrW-1:0] tail_ptr_r, tail_ptr_nxt;

  // Result stage.
  logic             out_valid_r, out_valid_nxt;
  logic             head_valid_r, head_valid_nxt;
  logic [FillW-1:0] fill_count_r, fill_count_nxt;
  logic             res_overflow_r, res_overflow_nxt;
  logic             byte_done_r, byte_done_nxt;
  logic [7:0]       rd_data_r;

  // FIFO memory.
  logic [7:0] fifo_mem [FIFO_DEPTH];

  // Combinational helpers.
  logic            accept;
  logic [PtrW:0]   fill_ext;
  logic [PtrW-1:0] fill_cnt;
  logic            fifo_nonempty;
  logic [PtrW-1:0] head_mid;
  logic [PtrW-1:0] tail_mid;
  logic [PtrW-1:0] tail_inc;
  logic            push;
  logic [7:0]      push_byte;
  logic            start_level;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;

  // Result fields; the head byte is forced to zero when nothing is held.
  assign out_data.head_byte  = head_valid_r ? rd_data_r : 8'd0;
  assign out_data.head_valid = head_valid_r;
  assign out_data.fill_count = fill_count_r;
  assign out_data.overflow   = res_overflow_r;
  assign out_data.byte_done  = byte_done_r;

  // Occupancy of the ring, which always leaves one slot free.
  always_comb begin
    if (tail_ptr_r >= head_ptr_r) begin
      fill_ext = {1'b0, tail_ptr_r} - {1'b0, head_ptr_r};
    end else begin
      fill_ext = {1'b0, tail_ptr_r} + DepthExt - {1'b0, head_ptr_r};
    end
    fill_cnt      = enable_r ? fill_ext[PtrW-1:0] : '0;
    fifo_nonempty = (fill_cnt != '0);
  end

  assign start_level = invert_r;

  // Next-state logic: configuration writes, then one receiver tick per item.
  always_comb begin
    enable_nxt       = enable_r;
    invert_nxt       = invert_r;
    center_delay_nxt = center_delay_r;
    bit_delay_nxt    = bit_delay_r;
    stop_delay_nxt   = stop_delay_r;
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    bit_index_nxt    = bit_index_r;
    shift_byte_nxt   = shift_byte_r;
    overflow_nxt     = overflow_r;
    head_ptr_nxt     = head_ptr_r;
    tail_ptr_nxt     = tail_ptr_r;
    head_mid         = head_ptr_r;
    tail_mid         = tail_ptr_r;
    tail_inc         = '0;
    push             = 1'b0;
    push_byte        = shift_byte_r ^ {8{invert_r}};
    byte_done_nxt    = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: begin
          if (cfg_wdata[0]) begin
            if (!enable_r) begin
              head_ptr_nxt   = '0;
              tail_ptr_nxt   = '0;
              overflow_nxt   = 1'b0;
              phase_nxt      = PH_IDLE;
              tick_count_nxt = '0;
              bit_index_nxt  = '0;
              shift_byte_nxt = '0;
            end
            enable_nxt = 1'b1;
          end else begin
            enable_nxt     = 1'b0;
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            bit_index_nxt  = '0;
            shift_byte_nxt = '0;
          end
        end
        CFG_INVERT:       invert_nxt       = cfg_wdata[0];
        CFG_CENTER_DELAY: center_delay_nxt = cfg_wdata;
        CFG_BIT_DELAY:    bit_delay_nxt    = cfg_wdata;
        CFG_STOP_DELAY:   stop_delay_nxt   = cfg_wdata;
        default: ;
      endcase
    end else if (accept && enable_r) begin
      // Pop, then flush.
      if (in_data.pop_request && (head_ptr_r != tail_ptr_r)) begin
        head_mid = (head_ptr_r == PtrLast) ? '0 : head_ptr_r + 1'b1;
      end
      if (in_data.flush_request) begin
        head_mid = '0;
        tail_mid = '0;
      end
      tail_inc     = (tail_mid == PtrLast) ? '0 : tail_mid + 1'b1;
      head_ptr_nxt = head_mid;
      tail_ptr_nxt = tail_mid;

      // Receiver tick.
      case (phase_r)
        PH_IDLE: begin
          if ((stop_delay_r != 16'd0) && (in_data.line_level == start_level)) begin
            phase_nxt      = PH_CENTER;
            tick_count_nxt = center_delay_r;
            bit_index_nxt  = '0;
            shift_byte_nxt = '0;
          end
        end
        PH_CENTER: begin
          if (tick_count_r > 16'd1) begin
            tick_count_nxt = tick_count_r - 16'd1;
          end else begin
            phase_nxt      = PH_DATA;
            tick_count_nxt = bit_delay_r;
          end
        end
        PH_DATA: begin
          if (tick_count_r > 16'd1) begin
            tick_count_nxt = tick_count_r - 16'd1;
          end else begin
            shift_byte_nxt[bit_index_r] = shift_byte_r[bit_index_r] | in_data.line_level;
            if (bit_index_r == 3'd7) begin
              phase_nxt      = PH_STOP;
              tick_count_nxt = stop_delay_r;
            end else begin
              bit_index_nxt  = bit_index_r + 3'd1;
              tick_count_nxt = bit_delay_r;
            end
          end
        end
        PH_STOP: begin
          if (tick_count_r > 16'd1) begin
            tick_count_nxt = tick_count_r - 16'd1;
          end else begin
            // Frame complete: push the byte or flag the drop.
            if (tail_inc != head_mid) begin
              push         = 1'b1;
              tail_ptr_nxt = tail_inc;
            end else begin
              overflow_nxt = 1'b1;
            end
            byte_done_nxt  = 1'b1;
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            bit_index_nxt  = '0;
            shift_byte_nxt = '0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Result stage next values.
  always_comb begin
    head_valid_nxt   = head_valid_r;
    fill_count_nxt   = fill_count_r;
    res_overflow_nxt = res_overflow_r;
    out_valid_nxt    = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt    = 1'b1;
      head_valid_nxt   = fifo_nonempty;
      fill_count_nxt   = FillW'(fill_cnt);
      res_overflow_nxt = overflow_nxt;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      invert_r       <= 1'b0;
      center_delay_r <= '0;
      bit_delay_r    <= '0;
      stop_delay_r   <= '0;
      phase_r        <= PH_IDLE;
      tick_count_r   <= '0;
      bit_index_r    <= '0;
      shift_byte_r   <= '0;
      overflow_r     <= 1'b0;
      head_ptr_r     <= '0;
      tail_ptr_r     <= '0;
      out_valid_r    <= 1'b0;
      head_valid_r   <= 1'b0;
      fill_count_r   <= '0;
      res_overflow_r <= 1'b0;
      byte_done_r    <= 1'b0;
    end else begin
      enable_r       <= enable_nxt;
      invert_r       <= invert_nxt;
      center_delay_r <= center_delay_nxt;
      bit_delay_r    <= bit_delay_nxt;
      stop_delay_r   <= stop_delay_nxt;
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_byte_r   <= shift_byte_nxt;
      overflow_r     <= overflow_nxt;
      head_ptr_r     <= head_ptr_nxt;
      tail_ptr_r     <= tail_ptr_nxt;
      out_valid_r    <= out_valid_nxt;
      head_valid_r   <= head_valid_nxt;
      fill_count_r   <= fill_count_nxt;
      res_overflow_r <= res_overflow_nxt;
      if (accept) begin
        byte_done_r <= byte_done_nxt;
      end
    end
  end

  // FIFO memory: one write port at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail_mid] <= push_byte;
    end
    if (accept) begin
      rd_data_r <= fifo_mem[head_ptr_r];
    end
  end

  // The receiver only runs while enabled.
  `UFR_ASSERT_NOW(a_rx_needs_enable, phase_r != PH_IDLE, enable_r)
  // A disabled receiver reports an empty FIFO.
  `UFR_ASSERT_NEXT(a_disabled_empty, accept && !enable_r,
                   !out_data.head_valid && (out_data.fill_count == '0))
  // Overflow stays set until the receiver is re-enabled or reset.
  `UFR_ASSERT_NEXT(a_overflow_sticky, enable_r && overflow_r && !cfg_we, overflow_r)
  // An expiring stop wait always reports a completed frame.
  `UFR_ASSERT_NEXT(a_stop_done,
                   accept && !cfg_we && enable_r && (phase_r == PH_STOP) &&
                   (tick_count_r <= 16'd1),
                   out_data.byte_done && (phase_r == PH_IDLE))

endmodule

// File: verif/uart_receiver_with_fifo_unit_test.sv
// Self-checking testbench for the UART receiver with receive FIFO.
`timescale 1ns / 1ps

module uart_receiver_with_fifo_unit_test;
  import ufr_pkg::*;

  typedef enum logic [1:0] {RX_IDLE, RX_CENTER, RX_DATA, RX_STOP} rx_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ufr_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ufr_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  uart_receiver_with_fifo_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted receiver and FIFO state.
  logic [7:0]  rx_fifo [64];
  logic [5:0]  rx_head = '0;
  logic [5:0]  rx_tail = '0;
  rx_phase_t   rx_state = RX_IDLE;
  logic [15:0] rx_wait = '0;
  logic [2:0]  rx_bit = '0;
  logic [7:0]  rx_shift = '0;
  logic        rx_overrun = 1'b0;

  // Predicted register contents.
  logic        r_enable = 1'b0;
  logic        r_invert = 1'b0;
  logic [15:0] r_center = '0;
  logic [15:0] r_bitdly = '0;
  logic [15:0] r_stop = '0;

  ufr_in_t  line_items [$];
  ufr_out_t expected_status [$];
  ufr_out_t want;
  int       items_queued = 0;
  logic     in_taken = 1'b0;
  logic     saw_error = 1'b0;

  int       send_idle_pct = 38;
  int       recv_stall_pct = 48;
  logic     hold_req = 1'b0;
  logic     hold_done = 1'b0;
  int       hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Give up well past the slowest correct run.
  initial begin
    #5000000;
    $display("[uart_receiver_with_fifo_unit] ERROR");
    $finish;
  end

  function automatic void rx_frame_clear();
    rx_state = RX_IDLE;
    rx_wait = '0;
    rx_bit = '0;
    rx_shift = '0;
  endfunction

  // One line tick: status before this tick's pop, then pop, flush and receive.
  function automatic ufr_out_t predict_tick(ufr_in_t it);
    ufr_out_t   r;
    logic [5:0] cnt;
    logic [5:0] nxt;
    logic [7:0] d;
    r = '0;
    cnt = r_enable ? (rx_tail - rx_head) : 6'd0;
    r.fill_count = cnt;
    r.head_valid = (cnt != 6'd0);
    r.head_byte = (cnt != 6'd0) ? rx_fifo[rx_head] : 8'h00;
    if (r_enable) begin
      if (it.pop_request && rx_head != rx_tail) rx_head = rx_head + 6'd1;
      if (it.flush_request) begin
        rx_head = '0;
        rx_tail = '0;
      end
      if (rx_state == RX_IDLE) begin
        // A start level opens a frame unless the stop delay is zero.
        if (r_stop != 16'd0 && it.line_level == r_invert) begin
          rx_state = RX_CENTER;
          rx_wait = r_center;
          rx_bit = '0;
          rx_shift = '0;
        end
      end else if (rx_wait > 16'd1) begin
        rx_wait = rx_wait - 16'd1;
      end else if (rx_state == RX_CENTER) begin
        rx_state = RX_DATA;
        rx_wait = r_bitdly;
      end else if (rx_state == RX_DATA) begin
        if (it.line_level) rx_shift[rx_bit] = 1'b1;
        if (rx_bit == 3'd7) begin
          rx_state = RX_STOP;
          rx_wait = r_stop;
        end else begin
          rx_bit = rx_bit + 3'd1;
          rx_wait = r_bitdly;
        end
      end else begin
        // Frame complete: push, or drop and flag when the ring is full.
        d = r_invert ? ~rx_shift : rx_shift;
        nxt = rx_tail + 6'd1;
        if (nxt != rx_head) begin
          rx_fifo[rx_tail] = d;
          rx_tail = nxt;
        end else begin
          rx_overrun = 1'b1;
        end
        rx_frame_clear();
        r.byte_done = 1'b1;
      end
    end
    r.overflow = rx_overrun;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      saw_error = 1'b1;
    end
  endfunction

  // Monitor: predict on every accepted item, compare every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) expected_status.push_back(predict_tick(in_data));
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result item with nothing expected");
          saw_error = 1'b1;
        end else begin
          want = expected_status.pop_front();
          check_field("head_byte", want.head_byte, out_data.head_byte);
          check_field("head_valid", 8'(want.head_valid), 8'(out_data.head_valid));
          check_field("fill_count", 8'(want.fill_count), 8'(out_data.fill_count));
          check_field("overflow", 8'(want.overflow), 8'(out_data.overflow));
          check_field("byte_done", 8'(want.byte_done), 8'(out_data.byte_done));
        end
      end
    end
  end

  // Driver: offers the next line item, holding it until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (line_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= line_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE: begin
        if (val[0]) begin
          // Turning on from off empties the ring and clears the flag.
          if (!r_enable) begin
            rx_head = '0;
            rx_tail = '0;
            rx_overrun = 1'b0;
            rx_frame_clear();
          end
          r_enable = 1'b1;
        end else begin
          r_enable = 1'b0;
          rx_frame_clear();
        end
      end
      CFG_INVERT:       r_invert = val[0];
      CFG_CENTER_DELAY: r_center = val;
      CFG_BIT_DELAY:    r_bitdly = val;
      CFG_STOP_DELAY:   r_stop = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (line_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic queue_raw(logic lvl, logic pop, logic flush);
    ufr_in_t it;
    it.line_level = lvl;
    it.pop_request = pop;
    it.flush_request = flush;
    line_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_item(logic lvl, int pop_pct, int flush_pct);
    queue_raw(lvl, $urandom_range(99) < pop_pct, $urandom_range(99) < flush_pct);
  endtask

  task automatic queue_idle(int n, int pop_pct);
    repeat (n) queue_item(!r_invert, pop_pct, 0);
  endtask

  task automatic queue_noise(int n, int pop_pct, int flush_pct);
    repeat (n) queue_item(1'($urandom_range(1)), pop_pct, flush_pct);
  endtask

  // Line ticks of one 8N1 frame at the current timing; cut > 0 truncates it.
  task automatic queue_frame(logic [7:0] bits, int cut, int pop_pct, int flush_pct);
    int   ce, be, se, n, j;
    logic lvl;
    ce = (r_center == 0) ? 1 : r_center;
    be = (r_bitdly == 0) ? 1 : r_bitdly;
    se = (r_stop == 0) ? 1 : r_stop;
    n = 1 + ce + 8 * be + se;
    if (cut > 0 && cut < n) n = cut;
    for (j = 0; j < n; j++) begin
      if (j <= ce) lvl = r_invert;
      else if (j <= ce + 8 * be) lvl = bits[(j - ce - 1) / be];
      else lvl = !r_invert;
      queue_item(lvl, pop_pct, flush_pct);
    end
  endtask

  task automatic random_setup();
    write_reg(CFG_INVERT, 16'($urandom_range(1)));
    write_reg(CFG_CENTER_DELAY, 16'($urandom_range(3)));
    write_reg(CFG_BIT_DELAY, 16'($urandom_range(3)));
    write_reg(CFG_STOP_DELAY, 16'($urandom_range(3, 1)));
    if ($urandom_range(1)) write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
  endtask

  // Mostly clean frames with random bytes, some truncated frames and noise.
  task automatic random_phase(int n_items, int pop_pct, int flush_pct);
    int stop_at, kind;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        queue_frame(8'($urandom_range(255)), 0, pop_pct, flush_pct);
        queue_idle($urandom_range(3), pop_pct);
      end else if (kind == 7) begin
        queue_frame(8'($urandom_range(255)), $urandom_range(20, 1), pop_pct, flush_pct);
      end else begin
        queue_noise($urandom_range(8, 1), pop_pct, flush_pct);
      end
    end
    // Let any frame in progress run out on an idle line.
    queue_idle(32, pop_pct);
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender idles more lightly than the result side stalls.
    send_idle_pct = 38;
    recv_stall_pct = 48;

    // While disabled, line, pop and flush are all ignored.
    queue_raw(1'b1, 1'b1, 1'b1);
    queue_raw(1'b0, 1'b1, 1'b0);
    queue_raw(1'b0, 1'b0, 1'b1);
    queue_raw(1'b1, 1'b0, 1'b0);
    wait_drain();

    // Zero stop delay blocks a start; pop and flush on an empty ring.
    write_reg(CFG_INVERT, 16'd0);
    write_reg(CFG_CENTER_DELAY, 16'd0);
    write_reg(CFG_BIT_DELAY, 16'd0);
    write_reg(CFG_STOP_DELAY, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    queue_raw(1'b0, 1'b1, 1'b0);
    queue_raw(1'b0, 1'b0, 1'b1);
    queue_raw(1'b0, 1'b1, 1'b1);
    wait_drain();

    // One clean frame, then pop it.
    write_reg(CFG_STOP_DELAY, 16'd1);
    queue_frame(8'hA5, 0, 0, 0);
    queue_raw(1'b1, 1'b1, 1'b0);
    queue_raw(1'b1, 1'b1, 1'b0);
    wait_drain();

    // Stop delay dropped to zero with a frame in progress.
    write_reg(CFG_STOP_DELAY, 16'd3);
    queue_frame(8'h00, 5, 0, 0);
    wait_drain();
    write_reg(CFG_STOP_DELAY, 16'd0);
    queue_idle(8, 0);
    wait_drain();

    // Largest delays under inverse logic, then abort by disabling.
    write_reg(CFG_INVERT, 16'd1);
    write_reg(CFG_CENTER_DELAY, 16'hFFFF);
    write_reg(CFG_BIT_DELAY, 16'hFFFF);
    write_reg(CFG_STOP_DELAY, 16'hFFFF);
    queue_raw(1'b1, 1'b0, 1'b0);
    queue_noise(6, 50, 0);
    wait_drain();
    write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);

    random_setup();
    random_phase(30, 25, 2);

    // Result side now idles more lightly than the sender.
    send_idle_pct = 48;
    recv_stall_pct = 38;

    // Fill the ring past full without pops, then drain it.
    write_reg(CFG_INVERT, 16'd0);
    write_reg(CFG_CENTER_DELAY, 16'd0);
    write_reg(CFG_BIT_DELAY, 16'd0);
    write_reg(CFG_STOP_DELAY, 16'd1);
    write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    repeat (64) queue_frame(8'($urandom_range(255)), 0, 0, 0);
    wait_drain();
    // Enabling again while on keeps the ring and the overflow flag.
    write_reg(CFG_ENABLE, 16'd1);
    queue_idle(80, 85);
    wait_drain();

    random_setup();
    random_phase(20, 5, 1);

    // No idling, and one long hold-off so the input backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    random_setup();
    random_phase(60, 30, 2);
    random_setup();
    random_phase(30, 15, 2);

    wait_drain();
    repeat (4) @(posedge clk);
    if (!saw_error && expected_status.size() == 0) begin
      $display("[uart_receiver_with_fifo_unit] OK");
    end else begin
      $display("[uart_receiver_with_fifo_unit] ERROR");
    end
    $finish;
  end

endmodule
